// ===== hdl/grid_wall_follower_macros.svh =====
// ----------------------------------------------------------------------------
// Grid wall follower assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef GRID_WALL_FOLLOWER_MACROS_SVH
`define GRID_WALL_FOLLOWER_MACROS_SVH

// Same-cycle implication, clocked on clk and off while arst_n is low.
`define GWF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid wall follower check failed");

// Next-cycle implication, clocked on clk and off while arst_n is low.
`define GWF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid wall follower check failed");

`endif

// ===== hdl/gwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid wall follower package
// Grid geometry, command, status and register codes, and shared types.
// ----------------------------------------------------------------------------
package gwf_pkg;

	// Grid geometry; row and column fields are four bits wide.
	localparam int ROWS   = 16;
	localparam int COLS   = 16;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 4;
	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CODE_W = 8;

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

	// Commands.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FINISH   = 2'd1;
	localparam logic [1:0] STAT_NO_ENTRY = 2'd2;
	localparam logic [1:0] STAT_BOXED    = 2'd3;

	// Headings.
	localparam logic [1:0] HD_UP    = 2'd0;
	localparam logic [1:0] HD_RIGHT = 2'd1;
	localparam logic [1:0] HD_DOWN  = 2'd2;
	localparam logic [1:0] HD_LEFT  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENTRY   = 2'd0;
	localparam logic [1:0] CFG_FINISH  = 2'd1;
	localparam logic [1:0] CFG_EMPTY   = 2'd2;
	localparam logic [1:0] CFG_HEADING = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0] entry_code;
		logic [CODE_W-1:0] finish_code;
		logic [CODE_W-1:0] empty_code;
		logic [1:0]        start_heading;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CODE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] pos_row;
		logic [COL_W-1:0] pos_col;
		logic [1:0]       heading;
		logic [1:0]       status;
	} res_t;

	// Linear cell address, row-major.
	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c));
	endfunction

endpackage

// ===== hdl/gwf_maze_ram.sv =====
// ----------------------------------------------------------------------------
// Maze cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gwf_maze_ram
	import gwf_pkg::*;
(
	input  logic              clk,
	input  ram_req_t          req,
	output logic [CODE_W-1:0] rdata
);

	logic [CODE_W-1:0] mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== hdl/gwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Grid wall follower sequencer
// Runs cell writes, the entry scan and the left-hand step against the memory.
// ----------------------------------------------------------------------------
`include "grid_wall_follower_macros.svh"

module gwf_ctrl
	import gwf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  col,
	input  logic [CODE_W-1:0] cell_code,
	input  cfg_t              cfg,
	input  logic              slot_free,
	output ram_req_t          ram_req,
	input  logic [CODE_W-1:0] ram_rdata,
	output logic              res_valid,
	output res_t              res
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_CHK_FIN = 6'b000100,
		ST_TRY_RD  = 6'b001000,
		ST_TRY_CHK = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] walk_row_q;
	logic [COL_W-1:0] walk_col_q;
	logic [1:0]       walk_hd_q;
	logic [1:0]       status_q;
	logic [1:0]       try_hd_q;
	logic [1:0]       tries_q;

	// Scan issue position, and the registered position of the previous issue whose data is now on ram_rdata.
	logic [ROW_W-1:0] scan_row_q;
	logic [COL_W-1:0] scan_col_q;
	logic             scan_more_q;
	logic             rv_s1;
	logic [ROW_W-1:0] rrow_s1;
	logic [COL_W-1:0] rcol_s1;

	logic             accept;
	logic             scan_issue;
	logic             scan_last;
	logic             nb_ok;
	logic [ROW_W-1:0] nb_row;
	logic [COL_W-1:0] nb_col;
	logic             passable;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign scan_issue = (state_q == ST_SCAN) && scan_more_q;
	assign scan_last  = (scan_row_q == ROW_LAST) && (scan_col_q == COL_LAST);
	assign passable   = (ram_rdata == cfg.empty_code) || (ram_rdata == cfg.finish_code);

	// Neighbor of the walker along the heading under trial; off-grid is wall.
	always_comb begin
		nb_ok  = 1'b0;
		nb_row = walk_row_q;
		nb_col = walk_col_q;
		case (try_hd_q)
			HD_UP: begin
				nb_ok  = (walk_row_q != '0);
				nb_row = walk_row_q - 1'b1;
			end
			HD_RIGHT: begin
				nb_ok  = (walk_col_q < COL_LAST);
				nb_col = walk_col_q + 1'b1;
			end
			HD_DOWN: begin
				nb_ok  = (walk_row_q < ROW_LAST);
				nb_row = walk_row_q + 1'b1;
			end
			HD_LEFT: begin
				nb_ok  = (walk_col_q != '0);
				nb_col = walk_col_q - 1'b1;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_req       = '0;
		ram_req.waddr = cell_addr(row, col);
		ram_req.wdata = cell_code;
		ram_req.we    = accept && (cmd == CMD_WRITE) &&
			(32'(row) < ROWS) && (32'(col) < COLS);
		ram_req.raddr = cell_addr(walk_row_q, walk_col_q);
		if (accept && (cmd == CMD_STEP)) begin
			ram_req.re = 1'b1;
		end else if (scan_issue) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = cell_addr(scan_row_q, scan_col_q);
		end else if ((state_q == ST_TRY_RD) && nb_ok) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = cell_addr(nb_row, nb_col);
		end
	end

	assign res_valid   = (state_q == ST_DONE) && slot_free;
	assign res.pos_row = walk_row_q;
	assign res.pos_col = walk_col_q;
	assign res.heading = walk_hd_q;
	assign res.status  = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_row_q  <= '0;
			walk_col_q  <= '0;
			walk_hd_q   <= '0;
			status_q    <= STAT_OK;
			try_hd_q    <= '0;
			tries_q     <= '0;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			scan_more_q <= 1'b0;
			rv_s1       <= 1'b0;
			rrow_s1     <= '0;
			rcol_s1     <= '0;
		end else begin
			rv_s1   <= scan_issue;
			rrow_s1 <= scan_row_q;
			rcol_s1 <= scan_col_q;
			if (scan_issue) begin
				scan_more_q <= !scan_last;
				if (scan_col_q == COL_LAST) begin
					scan_col_q <= '0;
					scan_row_q <= scan_row_q + 1'b1;
				end else begin
					scan_col_q <= scan_col_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					status_q <= STAT_OK;
					if (accept) begin
						case (cmd)
							CMD_START: begin
								scan_row_q  <= '0;
								scan_col_q  <= '0;
								scan_more_q <= 1'b1;
								state_q     <= ST_SCAN;
							end
							CMD_STEP: begin
								state_q <= ST_CHK_FIN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rv_s1 && (ram_rdata == cfg.entry_code)) begin
						walk_row_q <= rrow_s1;
						walk_col_q <= rcol_s1;
						walk_hd_q  <= cfg.start_heading;
						state_q    <= ST_DONE;
					end else if (rv_s1 && (rrow_s1 == ROW_LAST) && (rcol_s1 == COL_LAST)) begin
						status_q <= STAT_NO_ENTRY;
						state_q  <= ST_DONE;
					end
				end
				ST_CHK_FIN: begin
					if (ram_rdata == cfg.finish_code) begin
						status_q <= STAT_FINISH;
						state_q  <= ST_DONE;
					end else begin
						try_hd_q <= walk_hd_q - 1'b1;
						tries_q  <= '0;
						state_q  <= ST_TRY_RD;
					end
				end
				ST_TRY_RD: begin
					if (nb_ok) begin
						state_q <= ST_TRY_CHK;
					end else if (tries_q == 2'd3) begin
						status_q <= STAT_BOXED;
						state_q  <= ST_DONE;
					end else begin
						try_hd_q <= try_hd_q + 1'b1;
						tries_q  <= tries_q + 1'b1;
					end
				end
				ST_TRY_CHK: begin
					if (passable) begin
						walk_row_q <= nb_row;
						walk_col_q <= nb_col;
						walk_hd_q  <= try_hd_q;
						state_q    <= ST_DONE;
					end else if (tries_q == 2'd3) begin
						status_q <= STAT_BOXED;
						state_q  <= ST_DONE;
					end else begin
						try_hd_q <= try_hd_q + 1'b1;
						tries_q  <= tries_q + 1'b1;
						state_q  <= ST_TRY_RD;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Cells are written only by an accepted write command.
	`GWF_ASSERT_IMP(a_write_only_on_cmd, ram_req.we, accept && (cmd == CMD_WRITE))
	// Read data is consumed only the cycle after a read was issued.
	`GWF_ASSERT_IMP(a_fin_data_ready, state_q == ST_CHK_FIN, $past(ram_req.re))
	`GWF_ASSERT_IMP(a_try_data_ready, state_q == ST_TRY_CHK, $past(ram_req.re))
	// A step taken on a finish cell leaves the walker where it stood.
	`GWF_ASSERT_NXT(a_hold_on_finish, (state_q == ST_CHK_FIN) && (ram_rdata == cfg.finish_code),
		$stable(walk_row_q) && $stable(walk_col_q) && $stable(walk_hd_q))

endmodule

// ===== hdl/grid_wall_follower.sv =====
// ----------------------------------------------------------------------------
// Grid wall follower
// Left-hand wall follower walking a stored 16 x 16 maze of 8-bit cell codes.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   -------   ----------------------   ------------------------------------
//   input     in_valid / in_ready      cmd, row, col, cell_code
//   output    out_valid / out_ready    pos_row, pos_col, heading, status
//   config    cfg_we (no wait)         cfg_index, cfg_data
//
// One command is worked at a time; the walker and its heading live in
// registers and the maze in a single-port-read memory with registered read
// data. A step makes one read of the walker's own cell, then up to four
// neighbor trials, each a read and a check (an off-grid neighbor is not read).
// A start command scans the grid at one cell a cycle. After reset the block
// is ready at once; the memory is not cleared. The result sits in an output
// register, so a new command is taken while the previous result still waits
// for out_ready.
// ----------------------------------------------------------------------------
module grid_wall_follower
	import gwf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Command channel.
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        cmd,
	input  logic [ROW_W-1:0]  row,
	input  logic [COL_W-1:0]  col,
	input  logic [CODE_W-1:0] cell_code,
	// Result channel.
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_W-1:0]  pos_row,
	output logic [COL_W-1:0]  pos_col,
	output logic [1:0]        heading,
	output logic [1:0]        status,
	// Configuration write port.
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CODE_W-1:0] cfg_data
);

	cfg_t              cfg_q;
	ram_req_t          ram_req;
	logic [CODE_W-1:0] ram_rdata;
	logic              slot_free;
	logic              res_valid;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;

	// Config registers; user must load them only while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_code    <= CODE_W'(2);
			cfg_q.finish_code   <= CODE_W'(3);
			cfg_q.empty_code    <= '0;
			cfg_q.start_heading <= HD_UP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENTRY:   cfg_q.entry_code    <= cfg_data;
				CFG_FINISH:  cfg_q.finish_code   <= cfg_data;
				CFG_EMPTY:   cfg_q.empty_code    <= cfg_data;
				CFG_HEADING: cfg_q.start_heading <= cfg_data[1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The sequencer may load a new result when the register is empty or is
	// handing its content over in this cycle.
	assign slot_free = !out_valid_q || out_ready;

	gwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.cell_code (cell_code),
		.cfg       (cfg_q),
		.slot_free (slot_free),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	gwf_maze_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_row   = out_q.pos_row;
	assign pos_col   = out_q.pos_col;
	assign heading   = out_q.heading;
	assign status    = out_q.status;

endmodule
